// ----- design/rsplit_pkg.sv -----
// Shared types and constants of the rectangle split table.
`timescale 1ns / 1ps
package rsplit_pkg;

  // Default table depth.
  localparam int unsigned MAX_RECTS_DEF = 256;

  // Serial divider widths: a 33-bit magnitude over a cell count of up to 256.
  localparam int unsigned DIV_NUM_W = 33;
  localparam int unsigned DIV_DEN_W = 9;

  // One table entry as it sits in the memory.
  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
    logic [31:0] bottom;
    logic [31:0] top;
    logic [31:0] share;
  } rect_t;

  localparam int unsigned RECT_W = $bits(rect_t);

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SMALL = 3'd1,
    ST_FULL  = 3'd2,
    ST_INDEX = 3'd3,
    ST_GRID  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REQ_SPLIT = 2'd0,
    REQ_GRID  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    CFG_MIN_SIZE = 3'd0,
    CFG_BX_MIN   = 3'd1,
    CFG_BX_MAX   = 3'd2,
    CFG_BY_MIN   = 3'd3,
    CFG_BY_MAX   = 3'd4
  } cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_OUT,
    S_SP_D,
    S_SP_M1,
    S_SP_M2,
    S_SP_CHK,
    S_SP_WR,
    S_GR_DX,
    S_GR_DY,
    S_GR_SH,
    S_GR_FILL,
    S_EMIT
  } state_e;

endpackage

// ----- design/rectangle_split_table_top.sv -----
// Top level of the rectangle split table: control, arithmetic and the entry memory.
`timescale 1ns / 1ps
// The block holds up to MAX_RECTS rectangles (Q16.16 edges, Q1.31 area share) in one
// memory with a registered read, and works on one transaction at a time.
// A read returns the entry; a split runs a memory read, two multiplier stages, then
// two write-backs to the single write port; a split refused for size stops at the
// size check; a bad index, a full table, a bad grid or an unused request type goes
// straight to the result. A grid restart runs three serial divisions (x step, y step,
// share) and then writes one cell per cycle. A finished result waits in an output
// register, so the next transaction is taken while the last one is still unread.
module rectangle_split_table_top
  import rsplit_pkg::*;
#(
  parameter int unsigned MAX_RECTS = MAX_RECTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [7:0]         entry_index_i,
  input  logic [15:0]        split_pos_i,
  input  logic               split_in_y_i,
  input  logic [4:0]         grid_nx_i,
  input  logic [4:0]         grid_ny_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [8:0]         count_now_o,
  output logic signed [31:0] out_left_o,
  output logic signed [31:0] out_right_o,
  output logic signed [31:0] out_bottom_o,
  output logic signed [31:0] out_top_o,
  output logic [31:0]        out_share_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_RECTS);
  localparam int unsigned CW = $clog2(MAX_RECTS + 1);

  // Edge value lo + sign * acc, which always lands inside the bounding range.
  function automatic logic [31:0] grid_edge_at(logic [31:0] lo, logic neg, logic [32:0] acc);
    logic [33:0] s;
    s = {{2{lo[31]}}, lo} + (neg ? (34'd0 - {1'b0, acc}) : {1'b0, acc});
    return s[31:0];
  endfunction

  // Count as seen on the 9-bit result field.
  function automatic logic [8:0] count9(logic [CW-1:0] c);
    logic [31:0] t;
    t = 32'(c);
    return t[8:0];
  endfunction

  // Control state.
  state_e        state_q, state_d;
  logic [CW-1:0] count_q;
  logic          out_valid_q;

  // Configuration registers.
  logic [30:0] min_q;
  logic [31:0] bx_min_q, bx_max_q, by_min_q, by_max_q;

  // Request and datapath registers.
  logic [AW-1:0]  idx_q;
  logic [15:0]    pos_q;
  logic           iny_q;
  rect_t          ent_q, upper_q;
  logic [32:0]    d_q;
  logic [31:0]    lo_q;
  logic [49:0]    p_q;
  logic [34:0]    c_q;
  logic [31:0]    shlo_q, shhi_q;
  logic [4:0]     nx_q, ny_q;
  logic [8:0]     n_q;
  logic           negx_q, negy_q;
  logic [32:0]    qx_q, qy_q;
  logic [8:0]     rx_q, ry_q;
  logic [31:0]    share_q;
  logic [31:0]    xlo_q, ylo_q;
  logic [32:0]    xacc_q, yacc_q;
  logic [8:0]     xrem_q, yrem_q;
  logic [4:0]     xi_q, yi_q;
  logic [AW-1:0]  k_q;

  // Pending result and output registers.
  logic [2:0]  res_status_q;
  logic [8:0]  res_count_q;
  rect_t       res_rect_q;
  logic [2:0]  out_status_q;
  logic [8:0]  out_count_q;
  rect_t       out_rect_q;

  // Memory and divider connections.
  logic          we;
  logic [AW-1:0] waddr;
  rect_t         wdata;
  rect_t         rdata;
  logic [31:0]   idx32;
  logic          div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den, div_rem;

  // Request decode at the input.
  logic        accept;
  logic [9:0]  n_in;
  logic        grid_bad;
  logic        idx_bad;
  logic        full;
  logic [32:0] dx, dy, magx, magy;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign n_in     = {5'd0, grid_nx_i} * {5'd0, grid_ny_i};
  assign grid_bad = (grid_nx_i == 5'd0) || (grid_ny_i == 5'd0) || (grid_nx_i > 5'd16) ||
                    (grid_ny_i > 5'd16) || (32'(n_in) > MAX_RECTS);
  assign idx32    = 32'(entry_index_i);
  assign idx_bad  = idx32 >= 32'(count_q);
  assign full     = 32'(count_q) >= MAX_RECTS;
  assign dx       = {bx_max_q[31], bx_max_q} - {bx_min_q[31], bx_min_q};
  assign dy       = {by_max_q[31], by_max_q} - {by_min_q[31], by_min_q};
  assign magx     = dx[32] ? (33'd0 - dx) : dx;
  assign magy     = dy[32] ? (33'd0 - dy) : dy;

  // Split arithmetic on registered operands.
  logic signed [34:0] min35, dmc;
  logic               too_small;
  logic [31:0]        cut;
  logic               p_adj;
  rect_t              upper_d;
  assign min35     = $signed({4'b0, min_q});
  assign dmc       = $signed({{2{d_q[32]}}, d_q}) - $signed(c_q);
  assign too_small = ($signed(c_q) < min35) || (dmc < min35);
  assign cut       = lo_q + c_q[31:0];
  assign p_adj     = p_q[49] && (p_q[15:0] != 16'd0);

  // Upper part of the cut entry, appended at the end of the table.
  always_comb begin
    upper_d       = ent_q;
    upper_d.share = shhi_q;
    if (iny_q) begin
      upper_d.bottom = cut;
    end else begin
      upper_d.left = cut;
    end
  end

  // Grid sweep: the upper edges of the current cell and the step of each accumulator.
  logic [31:0] xhi, yhi;
  logic [9:0]  xsum, ysum;
  logic        xwrap, ywrap;
  logic        y_last, x_last;
  assign xhi    = grid_edge_at(bx_min_q, negx_q, xacc_q);
  assign yhi    = grid_edge_at(by_min_q, negy_q, yacc_q);
  assign xsum   = {1'b0, xrem_q} + {1'b0, rx_q};
  assign ysum   = {1'b0, yrem_q} + {1'b0, ry_q};
  assign xwrap  = xsum >= {5'd0, nx_q};
  assign ywrap  = ysum >= {5'd0, ny_q};
  assign y_last = yi_q == (ny_q - 5'd1);
  assign x_last = xi_q == (nx_q - 5'd1);

  logic out_load;
  assign out_load = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  // Next state, divider start and memory write selection.
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_num   = 33'h0_8000_0000;
    div_den   = n_q;
    we        = 1'b0;
    waddr     = idx_q;
    wdata     = ent_q;
    unique case (state_q)
      S_IDLE: begin
        div_num = magx;
        div_den = {4'd0, grid_nx_i};
        if (accept) begin
          unique case (req_e'(req_type_i))
            REQ_SPLIT: state_d = (idx_bad || full) ? S_EMIT : S_SP_D;
            REQ_READ:  state_d = idx_bad ? S_EMIT : S_RD_OUT;
            REQ_GRID: begin
              if (grid_bad) begin
                state_d = S_EMIT;
              end else begin
                div_start = 1'b1;
                state_d   = S_GR_DX;
              end
            end
            REQ_NONE:  state_d = S_EMIT;
            default:   state_d = S_EMIT;
          endcase
        end
      end
      S_RD_OUT: state_d = S_EMIT;
      S_SP_D:   state_d = S_SP_M1;
      S_SP_M1:  state_d = S_SP_M2;
      S_SP_M2:  state_d = S_SP_CHK;
      S_SP_CHK: begin
        if (too_small) begin
          state_d = S_EMIT;
        end else begin
          we      = 1'b1;
          waddr   = idx_q;
          wdata   = ent_q;
          wdata.share = shlo_q;
          if (iny_q) begin
            wdata.top = cut;
          end else begin
            wdata.right = cut;
          end
          state_d = S_SP_WR;
        end
      end
      S_SP_WR: begin
        we      = 1'b1;
        waddr   = count_q[AW-1:0];
        wdata   = upper_q;
        state_d = S_EMIT;
      end
      S_GR_DX: begin
        div_num = magy;
        div_den = {4'd0, ny_q};
        if (div_done) begin
          div_start = 1'b1;
          state_d   = S_GR_DY;
        end
      end
      S_GR_DY: begin
        if (div_done) begin
          div_start = 1'b1;
          state_d   = S_GR_SH;
        end
      end
      S_GR_SH: begin
        if (div_done) begin
          state_d = S_GR_FILL;
        end
      end
      S_GR_FILL: begin
        we    = 1'b1;
        waddr = k_q;
        wdata = '{left: xlo_q, right: xhi, bottom: ylo_q, top: yhi, share: share_q};
        if (y_last && x_last) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      min_q       <= '0;
      bx_min_q    <= '0;
      bx_max_q    <= 32'd65536;
      by_min_q    <= '0;
      by_max_q    <= 32'd65536;
    end else begin
      state_q <= state_d;
      if (state_q == S_SP_WR) begin
        count_q <= count_q + 1'b1;
      end else if (state_q == S_GR_FILL && y_last && x_last) begin
        count_q <= CW'(n_q);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // Configuration writes; an index past the list is ignored.
      if (cfg_valid_i) begin
        unique case (cfg_e'(cfg_index_i))
          CFG_MIN_SIZE: min_q    <= cfg_data_i[30:0];
          CFG_BX_MIN:   bx_min_q <= cfg_data_i;
          CFG_BX_MAX:   bx_max_q <= cfg_data_i;
          CFG_BY_MIN:   by_min_q <= cfg_data_i;
          CFG_BY_MAX:   by_max_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        idx_q  <= idx32[AW-1:0];
        pos_q  <= split_pos_i;
        iny_q  <= split_in_y_i;
        nx_q   <= grid_nx_i;
        ny_q   <= grid_ny_i;
        n_q    <= n_in[8:0];
        negx_q <= dx[32];
        negy_q <= dy[32];
        res_rect_q  <= '0;
        if (accept && (req_e'(req_type_i) == REQ_GRID) && !grid_bad) begin
          res_count_q <= n_in[8:0];
        end else begin
          res_count_q <= count9(count_q);
        end
        if (accept) begin
          unique case (req_e'(req_type_i))
            REQ_SPLIT: res_status_q <= idx_bad ? ST_INDEX : (full ? ST_FULL : ST_OK);
            REQ_READ:  res_status_q <= idx_bad ? ST_INDEX : ST_OK;
            REQ_GRID:  res_status_q <= grid_bad ? ST_GRID : ST_OK;
            REQ_NONE:  res_status_q <= ST_OK;
            default:   res_status_q <= ST_OK;
          endcase
        end
      end
      S_RD_OUT: res_rect_q <= rdata;
      S_SP_D: begin
        ent_q <= rdata;
        lo_q  <= iny_q ? rdata.bottom : rdata.left;
        d_q   <= iny_q ? ({rdata.top[31], rdata.top} - {rdata.bottom[31], rdata.bottom})
                       : ({rdata.right[31], rdata.right} - {rdata.left[31], rdata.left});
      end
      S_SP_M1: begin
        p_q    <= 50'($signed(d_q) * $signed({1'b0, pos_q}));
        shlo_q <= 32'((48'(ent_q.share) * 48'(pos_q)) >> 16);
      end
      S_SP_M2: begin
        c_q    <= 35'($signed({p_q[49], p_q[49:16]}) + $signed({34'd0, p_adj}));
        shhi_q <= 32'((49'(ent_q.share) * (49'd65536 - 49'(pos_q))) >> 16);
      end
      S_SP_CHK: begin
        upper_q <= upper_d;
        if (too_small) begin
          res_status_q <= ST_SMALL;
        end
      end
      S_SP_WR: begin
        res_status_q <= ST_OK;
        res_count_q  <= count9(count_q + 1'b1);
        res_rect_q   <= upper_q;
      end
      S_GR_DX: begin
        if (div_done) begin
          qx_q <= div_quo;
          rx_q <= div_rem;
        end
      end
      S_GR_DY: begin
        if (div_done) begin
          qy_q <= div_quo;
          ry_q <= div_rem;
        end
      end
      S_GR_SH: begin
        share_q <= div_quo[31:0];
        xlo_q   <= bx_min_q;
        xacc_q  <= qx_q;
        xrem_q  <= rx_q;
        ylo_q   <= by_min_q;
        yacc_q  <= qy_q;
        yrem_q  <= ry_q;
        xi_q    <= '0;
        yi_q    <= '0;
        k_q     <= '0;
      end
      S_GR_FILL: begin
        k_q <= k_q + 1'b1;
        if (y_last) begin
          // Next column: restart y and step x.
          yi_q   <= '0;
          ylo_q  <= by_min_q;
          yacc_q <= qy_q;
          yrem_q <= ry_q;
          xi_q   <= xi_q + 5'd1;
          xlo_q  <= xhi;
          xacc_q <= xacc_q + qx_q + 33'(xwrap);
          xrem_q <= xwrap ? 9'(xsum - {5'd0, nx_q}) : xsum[8:0];
        end else begin
          yi_q   <= yi_q + 5'd1;
          ylo_q  <= yhi;
          yacc_q <= yacc_q + qy_q + 33'(ywrap);
          yrem_q <= ywrap ? 9'(ysum - {5'd0, ny_q}) : ysum[8:0];
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_status_q <= res_status_q;
          out_count_q  <= res_count_q;
          out_rect_q   <= res_rect_q;
        end
      end
      default: ;
    endcase
  end

  // Entry memory, read at the requested index in the cycle of acceptance.
  rsplit_ram #(
    .WIDTH(RECT_W),
    .DEPTH(MAX_RECTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(idx32[AW-1:0]),
    .rdata_o(rdata)
  );

  // Shared serial divider for the grid steps and the cell share.
  rsplit_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  assign in_stall_o   = state_q != S_IDLE;
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign count_now_o  = out_count_q;
  assign out_left_o   = out_rect_q.left;
  assign out_right_o  = out_rect_q.right;
  assign out_bottom_o = out_rect_q.bottom;
  assign out_top_o    = out_rect_q.top;
  assign out_share_o  = out_rect_q.share;

endmodule

// ----- design/rsplit_ram.sv -----
// Generic single-write, single-read memory with registered read data.
`timescale 1ns / 1ps
module rsplit_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/rsplit_div.sv -----
// Restoring unsigned divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps
module rsplit_div
  import rsplit_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic                 done_o,
  output logic [DIV_NUM_W-1:0] quo_o,
  output logic [DIV_DEN_W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(DIV_NUM_W);

  logic                 busy_q;
  logic                 done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [DIV_NUM_W-1:0] num_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_DEN_W:0]   trial;
  logic                 ge;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_q, num_q[DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend register fills with quotient bits as it empties.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DIV_NUM_W-2:0], ge};
      rem_q <= ge ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;
  assign rem_o  = rem_q;

endmodule

// ----- tb/rectangle_split_table_top_tb.sv -----
// Self-checking testbench of the rectangle split table with a table predictor.
`timescale 1ns / 1ps

// Predicts each result from its own copy of the table and checks results in order.
class rect_table_model;
  typedef struct packed {
    logic [2:0]         status;
    logic [8:0]         count;
    logic signed [31:0] left;
    logic signed [31:0] right;
    logic signed [31:0] bottom;
    logic signed [31:0] top;
    logic [31:0]        share;
  } rect_result_t;

  logic [30:0]        min_size;
  logic signed [31:0] bx_min, bx_max, by_min, by_max;
  logic signed [31:0] t_left[256], t_right[256], t_bottom[256], t_top[256];
  logic [31:0]        t_share[256];
  int unsigned        count;
  rect_result_t       expected_results[$];
  int unsigned        mismatches;
  int unsigned        results_seen;
  int unsigned        splits_done;
  int unsigned        grids_done;

  function new();
    min_size = 0;
    bx_min = 0;
    bx_max = 65536;
    by_min = 0;
    by_max = 65536;
    count = 0;
    mismatches = 0;
    results_seen = 0;
    splits_done = 0;
    grids_done = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      rsplit_pkg::CFG_MIN_SIZE: min_size = data[30:0];
      rsplit_pkg::CFG_BX_MIN:   bx_min = data;
      rsplit_pkg::CFG_BX_MAX:   bx_max = data;
      rsplit_pkg::CFG_BY_MIN:   by_min = data;
      rsplit_pkg::CFG_BY_MAX:   by_max = data;
      default: ;
    endcase
  endfunction

  // Edge i of n equal cells between lo and hi, truncated toward zero.
  function logic signed [31:0] cell_edge(logic signed [31:0] lo, logic signed [31:0] hi,
                                         int unsigned i, int unsigned n);
    longint span;
    span = longint'(hi) - longint'(lo);
    return 32'(longint'(lo) + (longint'(i) * span) / longint'(n));
  endfunction

  function void note_request(logic [1:0] req, logic [7:0] idx, logic [15:0] pos,
                             logic in_y, logic [4:0] nx, logic [4:0] ny);
    rect_result_t r;
    longint lo, hi, d, c;
    longint unsigned sh;
    int unsigned k;
    r = '{rsplit_pkg::ST_OK, count[8:0], 0, 0, 0, 0, 0};
    case (req)
      rsplit_pkg::REQ_SPLIT: begin
        if (idx >= count) begin
          r.status = rsplit_pkg::ST_INDEX;
        end else if (count >= 256) begin
          r.status = rsplit_pkg::ST_FULL;
        end else begin
          lo = in_y ? t_bottom[idx] : t_left[idx];
          hi = in_y ? t_top[idx] : t_right[idx];
          d = hi - lo;
          c = (d * longint'(pos)) / 65536;
          if (c < longint'(min_size) || d - c < longint'(min_size)) begin
            r.status = rsplit_pkg::ST_SMALL;
          end else begin
            t_left[count] = t_left[idx];
            t_right[count] = t_right[idx];
            t_bottom[count] = t_bottom[idx];
            t_top[count] = t_top[idx];
            if (in_y) begin
              t_bottom[count] = 32'(lo + c);
              t_top[idx] = 32'(lo + c);
            end else begin
              t_left[count] = 32'(lo + c);
              t_right[idx] = 32'(lo + c);
            end
            sh = t_share[idx];
            t_share[count] = 32'((sh * (65536 - longint'(pos))) >> 16);
            t_share[idx] = 32'((sh * longint'(pos)) >> 16);
            r = '{rsplit_pkg::ST_OK, 9'(count + 1), t_left[count], t_right[count],
                  t_bottom[count], t_top[count], t_share[count]};
            count++;
            splits_done++;
          end
        end
      end
      rsplit_pkg::REQ_GRID: begin
        if (nx == 0 || ny == 0 || nx > 16 || ny > 16) begin
          r.status = rsplit_pkg::ST_GRID;
        end else begin
          k = 0;
          for (int unsigned x = 0; x < nx; x++) begin
            for (int unsigned y = 0; y < ny; y++) begin
              t_left[k] = cell_edge(bx_min, bx_max, x, nx);
              t_right[k] = cell_edge(bx_min, bx_max, x + 1, nx);
              t_bottom[k] = cell_edge(by_min, by_max, y, ny);
              t_top[k] = cell_edge(by_min, by_max, y + 1, ny);
              t_share[k] = 32'h8000_0000 / (nx * ny);
              k++;
            end
          end
          count = nx * ny;
          r.count = count[8:0];
          grids_done++;
        end
      end
      rsplit_pkg::REQ_READ: begin
        if (idx >= count) begin
          r.status = rsplit_pkg::ST_INDEX;
        end else begin
          r = '{rsplit_pkg::ST_OK, count[8:0], t_left[idx], t_right[idx], t_bottom[idx],
                t_top[idx], t_share[idx]};
        end
      end
      default: ;
    endcase
    expected_results.insert(expected_results.size(), r);
  endfunction

  function void check_result(rect_result_t act);
    rect_result_t e;
    results_seen++;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result transaction: status %0d", act.status);
      return;
    end
    e = expected_results.pop_front();
    if (act !== e) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Mismatch exp st=%0d cnt=%0d l=%0d r=%0d b=%0d t=%0d sh=%h",
                 e.status, e.count, e.left, e.right, e.bottom, e.top, e.share);
        $display("         act st=%0d cnt=%0d l=%0d r=%0d b=%0d t=%0d sh=%h",
                 act.status, act.count, act.left, act.right, act.bottom, act.top,
                 act.share);
      end
    end
  endfunction
endclass

module rectangle_split_table_top_tb;
  import rsplit_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         req_type_i = REQ_NONE;
  logic [7:0]         entry_index_i = '0;
  logic [15:0]        split_pos_i = '0;
  logic               split_in_y_i = 1'b0;
  logic [4:0]         grid_nx_i = 5'd1;
  logic [4:0]         grid_ny_i = 5'd1;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         status_o;
  logic [8:0]         count_now_o;
  logic signed [31:0] out_left_o, out_right_o, out_bottom_o, out_top_o;
  logic [31:0]        out_share_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = CFG_MIN_SIZE;
  logic [31:0]        cfg_data_i = '0;

  rect_table_model table_model = new();
  int unsigned     items_sent = 0;
  int unsigned     cycles = 0;
  int unsigned     burst_left = 0;

  rectangle_split_table_top DUT (.*);

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Cycle counter that ends a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver stall pattern: free-running, light random, long blocking stretches, or heavy random.
  always @(negedge clk_i) begin
    case ((cycles / 500) % 4)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 9) < 3);
      2: out_stall_i <= ((cycles % 16) < 11);
      default: out_stall_i <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // Check every accepted result transaction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      table_model.check_result('{status_o, count_now_o, out_left_o, out_right_o,
                                 out_bottom_o, out_top_o, out_share_o});
    end
  end

  // Send one request transaction; the sender idles between bursts of random length.
  task automatic send_req(logic [1:0] req, logic [7:0] idx, logic [15:0] pos,
                          logic in_y, logic [4:0] nx, logic [4:0] ny);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    req_type_i <= req;
    entry_index_i <= idx;
    split_pos_i <= pos;
    split_in_y_i <= in_y;
    grid_nx_i <= nx;
    grid_ny_i <= ny;
    do @(posedge clk_i); while (in_stall_o);
    table_model.note_request(req, idx, pos, in_y, nx, ny);
    items_sent++;
  endtask

  // Wait until every expected result has arrived and the block has settled.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (table_model.expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    table_model.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_box(logic [31:0] ms, logic [31:0] x0, logic [31:0] x1,
                         logic [31:0] y0, logic [31:0] y1);
    drain();
    write_reg(CFG_MIN_SIZE, ms);
    write_reg(CFG_BX_MIN, x0);
    write_reg(CFG_BX_MAX, x1);
    write_reg(CFG_BY_MIN, y0);
    write_reg(CFG_BY_MAX, y1);
  endtask

  function automatic logic [15:0] pick_pos();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'(32768 + $urandom_range(0, 64) - 32);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Random requests: grid restarts followed by runs of valid splits and reads, plus noise.
  task automatic random_phase(int unsigned n);
    int unsigned sent;
    int unsigned run;
    logic [7:0]  idx;
    logic [4:0]  nx, ny;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 15) == 0) begin
        nx = 5'($urandom_range(1, 16));
        ny = 5'($urandom_range(1, 16));
      end else begin
        nx = 5'($urandom_range(1, 3));
        ny = 5'($urandom_range(1, 3));
      end
      send_req(REQ_GRID, 8'($urandom), 16'($urandom), 1'($urandom), nx, ny);
      sent++;
      run = $urandom_range(5, 40);
      repeat (run) begin
        if ($urandom_range(0, 9) == 0 || table_model.count == 0) begin
          idx = 8'($urandom);
        end else begin
          idx = 8'($urandom_range(0, table_model.count - 1));
        end
        case ($urandom_range(0, 19))
          0: send_req(REQ_NONE, 8'($urandom), 16'($urandom), 1'($urandom),
                      5'($urandom), 5'($urandom));
          1: send_req(REQ_GRID, 8'($urandom), 16'($urandom), 1'($urandom),
                      5'($urandom), 5'($urandom));
          2, 3, 4, 5, 6: send_req(REQ_READ, idx, 16'($urandom), 1'($urandom),
                                  5'($urandom), 5'($urandom));
          default: send_req(REQ_SPLIT, idx, pick_pos(), 1'($urandom),
                            5'($urandom), 5'($urandom));
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset box, read of an empty table, single cell, cuts and rejects.
    send_req(REQ_READ, 8'd0, 16'd0, 1'b0, 5'd1, 5'd1);
    send_req(REQ_SPLIT, 8'd0, 16'd100, 1'b0, 5'd1, 5'd1);
    send_req(REQ_GRID, 8'd0, 16'd0, 1'b0, 5'd1, 5'd1);
    send_req(REQ_READ, 8'd0, 16'd0, 1'b0, 5'd1, 5'd1);
    send_req(REQ_SPLIT, 8'd0, 16'd32768, 1'b0, 5'd1, 5'd1);
    send_req(REQ_SPLIT, 8'd1, 16'hFFFF, 1'b1, 5'd1, 5'd1);
    send_req(REQ_SPLIT, 8'd0, 16'd0, 1'b1, 5'd1, 5'd1);
    send_req(REQ_READ, 8'd2, 16'd0, 1'b0, 5'd1, 5'd1);
    send_req(REQ_READ, 8'd255, 16'd0, 1'b0, 5'd1, 5'd1);
    send_req(REQ_SPLIT, 8'd3, 16'd1, 1'b0, 5'd1, 5'd1);
    send_req(REQ_NONE, 8'hFF, 16'hFFFF, 1'b1, 5'd31, 5'd31);
    send_req(REQ_GRID, 8'd0, 16'd0, 1'b0, 5'd0, 5'd4);
    send_req(REQ_GRID, 8'd0, 16'd0, 1'b0, 5'd4, 5'd17);
    send_req(REQ_GRID, 8'd0, 16'd0, 1'b0, 5'd31, 5'd31);
    send_req(REQ_GRID, 8'd0, 16'd0, 1'b0, 5'd16, 5'd16);
    send_req(REQ_READ, 8'd255, 16'd0, 1'b0, 5'd1, 5'd1);
    send_req(REQ_SPLIT, 8'd17, 16'd30000, 1'b1, 5'd1, 5'd1);

    // Large minimum size and the widest box.
    set_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_req(REQ_GRID, 8'd0, 16'd0, 1'b0, 5'd1, 5'd1);
    send_req(REQ_SPLIT, 8'd0, 16'd32768, 1'b0, 5'd1, 5'd1);
    send_req(REQ_READ, 8'd0, 16'd0, 1'b0, 5'd1, 5'd1);
    send_req(REQ_GRID, 8'd0, 16'd0, 1'b0, 5'd3, 5'd7);

    // Inverted box: every cut leaves a negative part and is refused.
    set_box(32'd0, 32'd65536, 32'hFFFF_0000, 32'd100, 32'd0);
    send_req(REQ_GRID, 8'd0, 16'd0, 1'b0, 5'd2, 5'd2);
    send_req(REQ_SPLIT, 8'd1, 16'd0, 1'b0, 5'd1, 5'd1);
    send_req(REQ_SPLIT, 8'd2, 16'd40000, 1'b1, 5'd1, 5'd1);

    // Random phases over several box and minimum size settings.
    set_box(32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    random_phase(250);
    set_box(32'd0, 32'd0, 32'd65536, 32'd0, 32'd65536);
    random_phase(250);
    set_box(32'd256, 32'hFFF0_0000, 32'h0010_0000, 32'd0, 32'h0100_0000);
    random_phase(250);
    set_box(32'd0, 32'd0, 32'd20, 32'hFFFF_FFF0, 32'd16);
    random_phase(200);
    set_box(32'($urandom_range(0, 4096)), 32'($urandom), 32'($urandom),
            32'($urandom), 32'($urandom));
    random_phase(200);
    set_box(32'($urandom_range(0, 65536)), 32'hC000_0000, 32'h4000_0000,
            32'hF000_0000, 32'h3000_0000);
    random_phase(250);
    set_box(32'($urandom) >> 1, 32'($urandom), 32'($urandom), 32'($urandom),
            32'($urandom));
    random_phase(150);

    drain();
    $display("Sent %0d requests; %0d results checked, %0d splits and %0d grids applied.",
             items_sent, table_model.results_seen, table_model.splits_done,
             table_model.grids_done);
    $display("Mismatches: %0d", table_model.mismatches);
    if (table_model.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
